@@ rtl/core/insertion_sorter_defines.svh @@
// Assertion macros used by the sorter RTL.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define INS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("insertion sorter check failed");

// Next-cycle implication.
`define INS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("insertion sorter check failed");

`endif

@@ rtl/core/ins_pkg.sv @@
package ins_pkg;

    // Store depth and the width of a fill count that can hold the depth itself
    localparam int MAX_ITEMS = 64;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [31:0] t_value;
    typedef logic [CNT_W-1:0]   t_count;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;   // place the key, larger entries move up one cell
        logic drain;    // lower cells take the upper neighbor's value; top holds
    } t_cell_ctl;

endpackage

@@ rtl/core/ins_cell.sv @@
module ins_cell (
    input  logic              i_clk,
    input  ins_pkg::t_cell_ctl i_ctl,
    input  ins_pkg::t_value   i_key,
    input  logic              i_occupied,
    input  logic              i_left_occupied,
    input  logic              i_left_gt,
    input  ins_pkg::t_value   i_left_value,
    input  ins_pkg::t_value   i_right_value,
    output ins_pkg::t_value   o_value,
    output logic              o_gt
);
    import ins_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   w_take;

    // Entry strictly above the key: it must move up (equal values stay put)
    assign o_gt = i_occupied && (r_value > i_key);

    // This cell changes on insert if it moves up or is the first free slot
    assign w_take = o_gt || (!i_occupied && i_left_occupied);

    always_comb begin
        n_value = r_value;
        if (i_ctl.insert && w_take) begin
            n_value = i_left_gt ? i_left_value : i_key;
        end else if (i_ctl.drain) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ rtl/core/insertion_sorter.sv @@
// Streaming insertion sorter for signed 32-bit values.
// Input channel (i_valid / o_stall): one value per request, i_last closes the
// set. While filling, a request is taken every cycle: the key is compared in
// parallel against a row of MAX_ITEMS cells and placed when it is accepted,
// larger entries moving up one cell, so equal values keep arrival order.
// Output channel (o_valid / i_stall): after the request with i_last, the set
// comes out in ascending order starting the next cycle, one result per cycle
// while the receiver does not stall; o_last_out marks the final one.
// Draining shifts the whole row down by one cell per accepted result, and
// o_stall stays high until the final result is taken.
// Values past MAX_ITEMS are dropped; o_overflow is then high on every result
// of that run. A stalled result holds its value.
// Reset (synchronous, active low) empties the store, clears the overflow
// flag and returns to filling; no clearing pass is needed.
`include "insertion_sorter_defines.svh"

module insertion_sorter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ins_pkg::t_value i_value,
    input  logic            i_last,
    output logic            o_valid,
    input  logic            i_stall,
    output ins_pkg::t_value o_sorted_value,
    output logic            o_last_out,
    output logic            o_overflow
);
    import ins_pkg::*;

    typedef enum logic {
        S_FILL,
        S_DRAIN
    } t_state;

    t_state    r_state;
    t_count    r_count;
    logic      r_dropped;

    t_cell_ctl w_ctl;
    logic      w_in_accept;
    logic      w_out_accept;
    logic      w_full;
    logic      w_run_clear;

    t_value    w_value    [MAX_ITEMS];
    logic      w_gt       [MAX_ITEMS];
    logic      w_occupied [MAX_ITEMS];

    // Handshakes
    assign o_stall      = (r_state == S_DRAIN);
    assign o_valid      = (r_state == S_DRAIN);
    assign w_in_accept  = i_valid && !o_stall;
    assign w_out_accept = o_valid && !i_stall;
    assign w_full       = (r_count == CNT_W'(MAX_ITEMS));

    assign w_ctl.insert = w_in_accept && !w_full;
    assign w_ctl.drain  = w_out_accept;

    // Cell row: cell 0 holds the smallest entry
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            localparam t_count IDX = CNT_W'(gi);
            logic   w_left_occ;
            logic   w_left_gt;
            t_value w_left_val;
            t_value w_right_val;

            assign w_occupied[gi] = (r_count > IDX);

            if (gi == 0) begin : g_first
                assign w_left_occ = 1'b1;
                assign w_left_gt  = 1'b0;
                assign w_left_val = i_value;
            end else begin : g_inner
                assign w_left_occ = w_occupied[gi-1];
                assign w_left_gt  = w_gt[gi-1];
                assign w_left_val = w_value[gi-1];
            end

            if (gi == MAX_ITEMS - 1) begin : g_top
                assign w_right_val = w_value[gi];
            end else begin : g_below
                assign w_right_val = w_value[gi+1];
            end

            ins_cell u_cell (
                .i_clk           (i_clk),
                .i_ctl           (w_ctl),
                .i_key           (i_value),
                .i_occupied      (w_occupied[gi]),
                .i_left_occupied (w_left_occ),
                .i_left_gt       (w_left_gt),
                .i_left_value    (w_left_val),
                .i_right_value   (w_right_val),
                .o_value         (w_value[gi]),
                .o_gt            (w_gt[gi])
            );
        end
    endgenerate

    // Fill / drain sequencing, count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            case (r_state)
                S_FILL: begin
                    if (w_in_accept) begin
                        if (w_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_out_accept) begin
                        r_count <= r_count - CNT_W'(1);
                        if (r_count == CNT_W'(1)) begin
                            r_state   <= S_FILL;
                            r_dropped <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    // Result comes straight from the bottom cell
    assign o_sorted_value = w_value[0];
    assign o_last_out     = (r_count == CNT_W'(1));
    assign o_overflow     = r_dropped;

    // Nothing left of a run: back to filling, empty, flag cleared
    assign w_run_clear = !o_valid && (r_count == '0) && !o_overflow;

    // Checks
    `INS_ASSERT_NOW(a_drain_nonempty, i_clk, i_rst_n, o_valid, r_count != '0)
    `INS_ASSERT_NEXT(a_last_starts_drain, i_clk, i_rst_n, w_in_accept && i_last, o_valid)
    `INS_ASSERT_NEXT(a_final_ends_run, i_clk, i_rst_n, w_out_accept && o_last_out, w_run_clear)
    `INS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_ITEMS))

endmodule
